[rtl/wba_pkg.sv]
// Package with shared constants and types of the weighted block aggregation engine.
`default_nettype none
package wba_pkg;
	localparam int IMAGE_WIDTH  = 256;
	localparam int IMAGE_HEIGHT = 256;
	localparam int BLOCK_MAX    = 16;
	localparam int GROUP_MAX    = 32;

	localparam int STORE_DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int WIN_DEPTH   = BLOCK_MAX * BLOCK_MAX;
	localparam int WIN_AW      = $clog2(WIN_DEPTH);

	localparam int PSUM_W = 48;
	localparam int WSUM_W = 40;
	localparam int NUM_W  = PSUM_W + 1;
	localparam int CNT_W  = $clog2(NUM_W + 1);

	// Operation codes of the input beat.
	localparam logic [1:0] OP_LOAD_WIN = 2'd0;
	localparam logic [1:0] OP_ACCUM    = 2'd1;
	localparam logic [1:0] OP_READ     = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BLOCK  = 2'd2;

	// Handshake between the top level and the divider.
	typedef struct packed {
		logic start;
		logic done;
	} div_ctrl_t;
endpackage
`default_nettype wire

[rtl/wba_div.sv]
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module wba_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [wba_pkg::NUM_W-1:0]  num,
	input  wire logic [wba_pkg::WSUM_W-1:0] den,
	output wba_pkg::div_ctrl_t              ctrl,
	output logic      [wba_pkg::NUM_W-1:0]  quo
);
	import wba_pkg::*;

	logic [WSUM_W-1:0] rem_q;
	logic [NUM_W-1:0]  quo_q;
	logic [WSUM_W-1:0] den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [WSUM_W:0]   trial;
	logic              take;

	// One trial subtraction per cycle.
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		take  = trial >= {1'b0, den_q};
	end

	// Control: count the quotient bits and flag the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= take ? WSUM_W'(trial - {1'b0, den_q}) : trial[WSUM_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], take};
		end
	end

	assign ctrl.start = start;
	assign ctrl.done  = done_q;
	assign quo        = quo_q;

	// A start never arrives while a division runs.
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start) else $error("divider restarted while busy");
	// Done follows the last step.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without work");
	// Done and busy never overlap.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");
endmodule
`default_nettype wire

[rtl/weighted_block_aggregation.sv]
// Top level of the weighted block aggregation engine.
// Usage: the input channel (in_valid, in_stall) takes one beat per item: op 0
// loads a window coefficient, op 1 adds a weighted block pixel into the sum
// stores, op 2 reads one normalized pixel. Only op 2 returns a result beat on
// the output channel (out_valid, out_stall).
// Steps: a load is written while the sequencer is idle; an accumulate runs memory
// read, first multiply, rounding, second multiply and write back. A read goes
// through the bit-serial divider (49 quotient bits) when the weight sum is nonzero
// and the position is in range; its result beat is registered from the output state.
// Items are handled one at a time; in_stall is high while an item is in work.
// The output register holds a finished result while the receiver stalls; the
// next item is taken meanwhile, and a new result waits until the register frees.
// Reset: after arst_n releases, a clearing pass writes zero into all 65536
// entries of the sum memory, one a cycle; in_stall stays high until the pass ends.
// Configuration writes are taken at any time.
`default_nettype none
module weighted_block_aggregation (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [8:0]         cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         op,
	input  wire logic [7:0]         block_row,
	input  wire logic [7:0]         block_col,
	input  wire logic [3:0]         off_row,
	input  wire logic [3:0]         off_col,
	input  wire logic [4:0]         block_index,
	input  wire logic signed [15:0] sample_value,
	input  wire logic [23:0]        group_weight,
	input  wire logic [15:0]        window_coeff,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      pixel_value,
	output logic                    covered,
	output logic                    range_error
);
	import wba_pkg::*;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_MUL1  = 4'd2;
	localparam logic [3:0] ST_RND   = 4'd3;
	localparam logic [3:0] ST_MUL2  = 4'd4;
	localparam logic [3:0] ST_WR    = 4'd5;
	localparam logic [3:0] ST_RRD   = 4'd6;
	localparam logic [3:0] ST_DIV   = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	localparam logic signed [PSUM_W:0] PSUM_MAX = (PSUM_W+1)'(48'sh7FFF_FFFF_FFFF);
	localparam logic signed [PSUM_W:0] PSUM_MIN = -(PSUM_W+1)'(49'sh0_8000_0000_0000);

	logic [3:0] state_q;
	logic [STORE_AW-1:0] clr_addr_q;

	logic [8:0] width_q, height_q;
	logic [4:0] bsize_q;
	logic [8:0] w_eff, h_eff;
	logic [4:0] bs_eff;

	logic accept;
	logic [8:0] pos_r, pos_c;
	logic off_ok, acc_ok, rd_err;

	// Sum memory: pixel sum in the upper bits, weight sum below.
	logic [PSUM_W+WSUM_W-1:0] sum_mem [STORE_DEPTH];
	logic [PSUM_W+WSUM_W-1:0] sum_rdata_q, sum_wdata;
	logic [STORE_AW-1:0] sum_raddr, sum_waddr;
	logic sum_re, sum_we;

	logic [15:0] win_mem [WIN_DEPTH];
	logic [15:0] win_rdata_q;
	logic win_re, win_we;

	logic [STORE_AW-1:0] pos_q;
	logic signed [15:0] samp_q;
	logic [23:0] gw_q;
	logic err_q;
	logic [39:0] prod_s1;
	logic [25:0] ww_s2;
	logic signed [42:0] sw_s3;

	logic signed [PSUM_W-1:0] ps_cur;
	logic [WSUM_W-1:0] ws_cur;
	logic [WSUM_W:0] ws_add;
	logic signed [PSUM_W:0] ps_add;
	logic [WSUM_W-1:0] ws_new;
	logic signed [PSUM_W-1:0] ps_new;

	logic neg_q;
	logic [NUM_W-1:0] div_num;
	logic [PSUM_W-1:0] mag;
	logic [NUM_W-1:0] quo;
	div_ctrl_t div_ctrl;
	logic div_start;

	logic signed [15:0] res_val_q;
	logic res_cov_q, res_err_q;
	logic out_free;
	logic signed [15:0] div_val;

	// Register bounds act as clamped values.
	always_comb begin
		w_eff  = (width_q == 9'd0) ? 9'd1 :
			(width_q > 9'(IMAGE_WIDTH)) ? 9'(IMAGE_WIDTH) : width_q;
		h_eff  = (height_q == 9'd0) ? 9'd1 :
			(height_q > 9'(IMAGE_HEIGHT)) ? 9'(IMAGE_HEIGHT) : height_q;
		bs_eff = (bsize_q == 5'd0) ? 5'd1 :
			(bsize_q > 5'(BLOCK_MAX)) ? 5'(BLOCK_MAX) : bsize_q;
	end

	// Input decode and range checks.
	always_comb begin
		accept = in_valid && !in_stall;
		off_ok = ({1'b0, off_row} < bs_eff) && ({1'b0, off_col} < bs_eff);
		pos_r  = {1'b0, block_row} + {5'd0, off_row};
		pos_c  = {1'b0, block_col} + {5'd0, off_col};
		acc_ok = off_ok && (pos_r < h_eff) && (pos_c < w_eff)
			&& (32'(block_index) < GROUP_MAX);
		rd_err = ({1'b0, block_row} >= h_eff) || ({1'b0, block_col} >= w_eff);
		win_we = accept && (op == OP_LOAD_WIN) && off_ok;
		win_re = accept && (op == OP_ACCUM);
		sum_re = accept && ((op == OP_ACCUM) || (op == OP_READ));
		sum_raddr = (op == OP_READ) ? {block_row, block_col} : {pos_r[7:0], pos_c[7:0]};
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
			bsize_q  <= 5'd9;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_BLOCK:  bsize_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Window table memory.
	always_ff @(posedge clk) begin
		if (win_we)
			win_mem[{off_row, off_col}] <= window_coeff;
		if (win_re)
			win_rdata_q <= win_mem[{off_row, off_col}];
	end

	// Sum memory with one write and one read port.
	always_ff @(posedge clk) begin
		if (sum_we)
			sum_mem[sum_waddr] <= sum_wdata;
		if (sum_re)
			sum_rdata_q <= sum_mem[sum_raddr];
	end

	// Accumulate arithmetic with saturation.
	always_comb begin
		ps_cur = sum_rdata_q[PSUM_W+WSUM_W-1:WSUM_W];
		ws_cur = sum_rdata_q[WSUM_W-1:0];
		ws_add = {1'b0, ws_cur} + (WSUM_W+1)'(ww_s2);
		ws_new = ws_add[WSUM_W] ? {WSUM_W{1'b1}} : ws_add[WSUM_W-1:0];
		ps_add = (PSUM_W+1)'(ps_cur) + (PSUM_W+1)'(sw_s3);
		if (ps_add > PSUM_MAX)
			ps_new = PSUM_MAX[PSUM_W-1:0];
		else if (ps_add < PSUM_MIN)
			ps_new = PSUM_MIN[PSUM_W-1:0];
		else
			ps_new = ps_add[PSUM_W-1:0];
	end

	// Memory write: clearing pass or write back.
	always_comb begin
		sum_we    = (state_q == ST_CLEAR) || (state_q == ST_WR);
		sum_waddr = (state_q == ST_CLEAR) ? clr_addr_q : pos_q;
		sum_wdata = (state_q == ST_CLEAR) ? '0 : {ps_new, ws_new};
	end

	// Read path: divider operands and result selection.
	always_comb begin
		mag       = ps_cur[PSUM_W-1] ? PSUM_W'(-ps_cur) : PSUM_W'(ps_cur);
		div_num   = {1'b0, mag} + {1'b0, 9'd0, ws_cur[WSUM_W-1:1]};
		div_start = (state_q == ST_RRD) && !err_q && (ws_cur != '0);
		if (neg_q)
			div_val = (quo >= NUM_W'(32768)) ? -16'sd32768 : $signed(~quo[15:0] + 16'd1);
		else
			div_val = (quo >= NUM_W'(32767)) ? 16'sd32767 : $signed(quo[15:0]);
		out_free = !out_valid || !out_stall;
	end

	wba_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (ws_cur),
		.ctrl   (div_ctrl),
		.quo    (quo)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == {STORE_AW{1'b1}})
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						if (op == OP_ACCUM && acc_ok)
							state_q <= ST_MUL1;
						else if (op == OP_READ)
							state_q <= ST_RRD;
					end
				end
				ST_MUL1: state_q <= ST_RND;
				ST_RND:  state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_WR;
				ST_WR:   state_q <= ST_IDLE;
				ST_RRD:  state_q <= div_start ? ST_DIV : ST_OUT;
				ST_DIV: begin
					if (div_ctrl.done)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item payload and arithmetic pipeline registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q  <= {pos_r[7:0], pos_c[7:0]};
			samp_q <= sample_value;
			gw_q   <= group_weight;
			err_q  <= rd_err;
		end
		prod_s1 <= gw_q * win_rdata_q;
		ww_s2   <= 26'((41'(prod_s1) + 41'h4000) >> 15);
		sw_s3   <= 43'(samp_q) * $signed({17'd0, ww_s2});
		if (state_q == ST_RRD) begin
			neg_q     <= ps_cur[PSUM_W-1];
			res_val_q <= '0;
			res_cov_q <= 1'b0;
			res_err_q <= err_q;
		end else if (state_q == ST_DIV && div_ctrl.done) begin
			res_val_q <= div_val;
			res_cov_q <= 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			pixel_value <= res_val_q;
			covered     <= res_cov_q;
			range_error <= res_err_q;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	// Items are taken only when the sequencer is idle.
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("item taken while busy");
	// No result leaves during the clearing pass.
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !out_valid) else $error("result during clear");
	// A write back follows the second multiply.
	a_wr_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> $past(state_q) == ST_MUL2) else $error("bad write order");
	// A covered result never carries a range error.
	a_cov_err: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && covered) |-> !range_error) else $error("covered with error");
endmodule
`default_nettype wire
